>>> sv/vt4x4_pkg.sv
`timescale 1ns / 1ps

package vt4x4_pkg;

   localparam int NUM_ROWS        = 4;
   localparam int NUM_COLS        = 4;
   localparam int ROW_WIDTH       = 64;
   localparam int COLOR_WIDTH     = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int COEF_INT_BITS   = 4;
   localparam int PIPE_DEPTH      = 4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ROW_ZERO  = 3'd0,
      CSR_ROW_ONE   = 3'd1,
      CSR_ROW_TWO   = 3'd2,
      CSR_ROW_THREE = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic                       valid;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [ROW_WIDTH-1:0]       data;
   } csr_write_type;

   typedef logic [NUM_ROWS-1:0][ROW_WIDTH-1:0] matrix_type;

endpackage

>>> sv/vertex_transform_4x4_top.sv
`timescale 1ns / 1ps
// Path: a word taken at a clock edge passes the product, pair-sum, sum and result
// registers in that order before it is on the rsp_ ports.
// Throughput: one vertex per cycle; busy stays low, set by the four-stage row pipeline
// (multiply, pair add, final add and round, shift and saturate).
// Reset: synchronous; clears the valid pipeline and all matrix rows to zero.
// The receiver cannot stall; csr_ready stays high.
module vertex_transform_4x4_top #(
   parameter int COORD_WIDTH = 32,
   parameter int COEF_WIDTH  = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic [COORD_WIDTH-1:0]                    req_x_in,
   input  logic [COORD_WIDTH-1:0]                    req_y_in,
   input  logic [COORD_WIDTH-1:0]                    req_z_in,
   input  logic [COORD_WIDTH-1:0]                    req_w_in,
   input  logic [vt4x4_pkg::COLOR_WIDTH-1:0]         req_color_in,
   output logic                                      rsp_strobe,
   output logic [COORD_WIDTH-1:0]                    rsp_x_out,
   output logic [COORD_WIDTH-1:0]                    rsp_y_out,
   output logic [COORD_WIDTH-1:0]                    rsp_z_out,
   output logic [COORD_WIDTH-1:0]                    rsp_w_out,
   output logic [vt4x4_pkg::COLOR_WIDTH-1:0]         rsp_color_out,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [vt4x4_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [vt4x4_pkg::ROW_WIDTH-1:0]           csr_data
);

   vt4x4_pkg::csr_write_type                               csr_wr;
   vt4x4_pkg::matrix_type                                  matrix;
   logic [vt4x4_pkg::NUM_COLS-1:0][COORD_WIDTH-1:0]        coord;
   logic [vt4x4_pkg::NUM_ROWS-1:0][COORD_WIDTH-1:0]        row_result;
   logic [vt4x4_pkg::PIPE_DEPTH-1:0]                       valid_ff;
   logic [vt4x4_pkg::PIPE_DEPTH-1:0]                       valid_in;
   logic [vt4x4_pkg::COLOR_WIDTH-1:0]                      color_ff [vt4x4_pkg::PIPE_DEPTH];
   logic [vt4x4_pkg::COLOR_WIDTH-1:0]                      color_in [vt4x4_pkg::PIPE_DEPTH];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      csr_wr.valid = csr_valid && csr_ready;
      csr_wr.index = csr_index;
      csr_wr.data  = csr_data;
   end

   vt4x4_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .wr     (csr_wr),
      .matrix (matrix)
   );

   assign coord = {req_w_in, req_z_in, req_y_in, req_x_in};

   for (genvar r = 0; r < vt4x4_pkg::NUM_ROWS; r++) begin : g_row
      vt4x4_row #(
         .COORD_WIDTH (COORD_WIDTH),
         .COEF_WIDTH  (COEF_WIDTH)
      ) u_row (
         .clock    (clock),
         .coef_row (matrix[r]),
         .coord    (coord),
         .result   (row_result[r])
      );
   end

   // advance valid and colour alongside the row pipelines
   always_comb begin
      valid_in    = {valid_ff[vt4x4_pkg::PIPE_DEPTH-2:0], start && !busy};
      color_in[0] = req_color_in;
      for (int s = 1; s < vt4x4_pkg::PIPE_DEPTH; s++) begin
         color_in[s] = color_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff <= color_in;
   end

   assign rsp_strobe    = valid_ff[vt4x4_pkg::PIPE_DEPTH-1];
   assign rsp_x_out     = row_result[0];
   assign rsp_y_out     = row_result[1];
   assign rsp_z_out     = row_result[2];
   assign rsp_w_out     = row_result[3];
   assign rsp_color_out = color_ff[vt4x4_pkg::PIPE_DEPTH-1];

endmodule

>>> sv/vt4x4_csr.sv
`timescale 1ns / 1ps

module vt4x4_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  vt4x4_pkg::csr_write_type  wr,
   output vt4x4_pkg::matrix_type     matrix
);

   vt4x4_pkg::matrix_type matrix_ff;
   vt4x4_pkg::matrix_type matrix_in;

   always_comb begin
      matrix_in = matrix_ff;
      if (wr.valid) begin
         unique case (wr.index)
            vt4x4_pkg::CSR_ROW_ZERO:  matrix_in[0] = wr.data;
            vt4x4_pkg::CSR_ROW_ONE:   matrix_in[1] = wr.data;
            vt4x4_pkg::CSR_ROW_TWO:   matrix_in[2] = wr.data;
            vt4x4_pkg::CSR_ROW_THREE: matrix_in[3] = wr.data;
            default:                  matrix_in = matrix_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= '0;
      end else begin
         matrix_ff <= matrix_in;
      end
   end

   assign matrix = matrix_ff;

endmodule

>>> sv/vt4x4_row.sv
`timescale 1ns / 1ps

module vt4x4_row #(
   parameter int COORD_WIDTH = 32,
   parameter int COEF_WIDTH  = 16
) (
   input  logic                                                clock,
   input  logic [vt4x4_pkg::ROW_WIDTH-1:0]                     coef_row,
   input  logic [vt4x4_pkg::NUM_COLS-1:0][COORD_WIDTH-1:0]     coord,
   output logic [COORD_WIDTH-1:0]                              result
);

   localparam int PROD_WIDTH = COORD_WIDTH + COEF_WIDTH;
   localparam int PAIR_WIDTH = PROD_WIDTH + 1;
   localparam int SUM_WIDTH  = PROD_WIDTH + 2;
   localparam int FRAC       = COEF_WIDTH - vt4x4_pkg::COEF_INT_BITS;
   localparam int TOP_LSB    = FRAC + COORD_WIDTH - 1;
   localparam logic signed [SUM_WIDTH-1:0] HALF = SUM_WIDTH'(1) << (FRAC - 1);
   localparam logic [COORD_WIDTH-1:0] MAX_VAL = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] MIN_VAL = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic signed [COEF_WIDTH-1:0]  coef_s  [vt4x4_pkg::NUM_COLS];
   logic signed [COORD_WIDTH-1:0] coord_s [vt4x4_pkg::NUM_COLS];
   logic signed [PROD_WIDTH-1:0]  prod_in [vt4x4_pkg::NUM_COLS];
   logic signed [PROD_WIDTH-1:0]  prod_ff [vt4x4_pkg::NUM_COLS];
   logic signed [PAIR_WIDTH-1:0]  pair_in [2];
   logic signed [PAIR_WIDTH-1:0]  pair_ff [2];
   logic signed [SUM_WIDTH-1:0]   sum_in;
   logic signed [SUM_WIDTH-1:0]   sum_ff;
   logic [SUM_WIDTH-1:TOP_LSB]    sum_hi;
   logic [COORD_WIDTH-1:0]        result_in;
   logic [COORD_WIDTH-1:0]        result_ff;

   always_comb begin
      for (int c = 0; c < vt4x4_pkg::NUM_COLS; c++) begin
         coef_s[c]  = $signed(coef_row[c*COEF_WIDTH +: COEF_WIDTH]);
         coord_s[c] = $signed(coord[c]);
         prod_in[c] = coef_s[c] * coord_s[c];
      end
   end

   always_comb begin
      pair_in[0] = PAIR_WIDTH'(prod_ff[0]) + PAIR_WIDTH'(prod_ff[1]);
      pair_in[1] = PAIR_WIDTH'(prod_ff[2]) + PAIR_WIDTH'(prod_ff[3]);
   end

   assign sum_in = SUM_WIDTH'(pair_ff[0]) + SUM_WIDTH'(pair_ff[1]) + HALF;

   // saturate when the bits above the result do not all match its sign
   always_comb begin
      sum_hi = sum_ff[SUM_WIDTH-1:TOP_LSB];
      priority if ((&sum_hi) || !(|sum_hi)) begin
         result_in = sum_ff[TOP_LSB:FRAC];
      end else if (sum_ff[SUM_WIDTH-1]) begin
         result_in = MIN_VAL;
      end else begin
         result_in = MAX_VAL;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      pair_ff   <= pair_in;
      sum_ff    <= sum_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule
